@@ rtl/spr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared widths, register indexes, reset values and the control and status
// bundles that pass between the step pulse rate limiter modules.
// ----------------------------------------------------------------------------
package spr_pkg;

  // field and register widths
  localparam int DATA_W = 32;
  localparam int CLK_W  = 30;
  localparam int PSC_W  = 16;
  localparam int STEP_W = 32;
  localparam int LIM_W  = 31;
  localparam int RLD_W  = 13;
  localparam int CMP_W  = 12;
  localparam int IDX_W  = 3;
  localparam int PROD_W = CLK_W + STEP_W;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 3'd0;
  localparam logic [IDX_W-1:0] CFG_PRESCALER      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_STEP_SIZE      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_PRESSURE_LIMIT = 3'd4;
  localparam logic [IDX_W-1:0] CFG_DEADBAND       = 3'd5;

  // register reset values
  localparam logic [CLK_W-1:0]  RST_TIMER_CLOCK_HZ = 30'd84000000;
  localparam logic [PSC_W-1:0]  RST_PRESCALER      = 16'd83;
  localparam logic [STEP_W-1:0] RST_STEP_SIZE      = 32'd655;
  localparam logic [LIM_W-1:0]  RST_SPEED_LIMIT    = 31'd655360;
  localparam logic [LIM_W-1:0]  RST_PRESSURE_LIMIT = 31'd6553600;
  localparam logic [LIM_W-1:0]  RST_DEADBAND       = 31'd6554;

  // configuration register set
  typedef struct packed {
    logic [CLK_W-1:0]  timer_clock_hz;
    logic [PSC_W-1:0]  prescaler;
    logic [STEP_W-1:0] step_size;
    logic [LIM_W-1:0]  speed_limit;
    logic [LIM_W-1:0]  pressure_limit;
    logic [LIM_W-1:0]  deadband;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic eval;
    logic tdiv_init;
    logic tdiv_step;
    logic mul_lo;
    logic mul_hi;
    logic qdiv_init;
    logic qdiv_step;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic go;
    logic qbig;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/spr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_cfg
// Configuration register file, written one register per beat on the
// configuration channel. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module spr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [spr_pkg::IDX_W-1:0]      cfg_index,
  input  logic [spr_pkg::DATA_W-1:0]     cfg_data,
  output spr_pkg::cfg_t                  cfg
);

  // register writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_clock_hz <= spr_pkg::RST_TIMER_CLOCK_HZ;
      cfg.prescaler      <= spr_pkg::RST_PRESCALER;
      cfg.step_size      <= spr_pkg::RST_STEP_SIZE;
      cfg.speed_limit    <= spr_pkg::RST_SPEED_LIMIT;
      cfg.pressure_limit <= spr_pkg::RST_PRESSURE_LIMIT;
      cfg.deadband       <= spr_pkg::RST_DEADBAND;
    end else if (cfg_valid) begin
      case (cfg_index)
        spr_pkg::CFG_TIMER_CLOCK_HZ: cfg.timer_clock_hz <= cfg_data[spr_pkg::CLK_W-1:0];
        spr_pkg::CFG_PRESCALER:      cfg.prescaler      <= cfg_data[spr_pkg::PSC_W-1:0];
        spr_pkg::CFG_STEP_SIZE:      cfg.step_size      <= cfg_data[spr_pkg::STEP_W-1:0];
        spr_pkg::CFG_SPEED_LIMIT:    cfg.speed_limit    <= cfg_data[spr_pkg::LIM_W-1:0];
        spr_pkg::CFG_PRESSURE_LIMIT: cfg.pressure_limit <= cfg_data[spr_pkg::LIM_W-1:0];
        spr_pkg::CFG_DEADBAND:       cfg.deadband       <= cfg_data[spr_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/spr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer for one beat: input check, tick division, two-part multiply,
// quotient range check, short quotient division and output load.
// ----------------------------------------------------------------------------
module spr_ctrl #(
  parameter int QW = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spr_pkg::sts_t   sts,
  output spr_pkg::cmd_t   cmd
);

  localparam int TW   = spr_pkg::CLK_W;
  localparam int MAXN = (QW > TW) ? QW : TW;
  localparam int CW   = $clog2(MAXN + 1);

  localparam logic [CW-1:0] TDIV_LAST = CW'(TW - 1);
  localparam logic [CW-1:0] QDIV_LAST = CW'(QW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_TDIV = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_QCHK = 3'd5;
  localparam logic [2:0] S_QDIV = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.tdiv_init = 1'b1;
        cnt_next      = '0;
        state_next    = sts.go ? S_TDIV : S_DONE;
      end
      S_TDIV: begin
        cmd.tdiv_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == TDIV_LAST) begin
          state_next = S_MLO;
        end
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_QCHK;
      end
      S_QCHK: begin
        cmd.qdiv_init = 1'b1;
        cnt_next      = '0;
        state_next    = sts.qbig ? S_DONE : S_QDIV;
      end
      S_QDIV: begin
        cmd.qdiv_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == QDIV_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

@@ rtl/spr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_datapath
// Input limiting, restoring divider for the timer tick, shared 30x16
// multiplier, restoring divider for the low quotient bits, saturation and
// the output register with the held reload value.
// ----------------------------------------------------------------------------
module spr_datapath #(
  parameter int RELOAD_MIN = 1249,
  parameter int RELOAD_MAX = 4999,
  parameter int QW         = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spr_pkg::cmd_t                      cmd,
  output spr_pkg::sts_t                      sts,
  input  spr_pkg::cfg_t                      cfg,
  input  logic signed [spr_pkg::DATA_W-1:0]  speed_cmd,
  input  logic signed [spr_pkg::DATA_W-1:0]  pressure,
  input  logic signed [spr_pkg::DATA_W-1:0]  target,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               direction,
  output logic [spr_pkg::RLD_W-1:0]          reload,
  output logic [spr_pkg::CMP_W-1:0]          compare,
  output logic                               pulsing
);

  localparam int DW = spr_pkg::DATA_W;
  localparam int TW = spr_pkg::CLK_W;
  localparam int PW = spr_pkg::PROD_W;
  localparam int LW = spr_pkg::LIM_W;
  localparam int SW = spr_pkg::PSC_W + 1;
  localparam int HW = PW - QW;

  localparam logic [QW:0] MIN_P1 = (QW + 1)'(RELOAD_MIN + 1);
  localparam logic [QW:0] MIN_V  = (QW + 1)'(RELOAD_MIN);
  localparam logic [QW:0] MAX_V  = (QW + 1)'(RELOAD_MAX);

  // captured input beat
  logic signed [DW-1:0] spd, prs, tgt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      spd <= speed_cmd;
      prs <= pressure;
      tgt <= target;
    end
  end

  // over-pressure stop, speed clamp, direction and deadband test
  logic signed [DW:0] prs_x, spd_x, err;
  logic [DW:0]        pmag, smag_full, errmag;
  logic               over, dir_c, go_c;
  logic [LW-1:0]      smag_c;

  always_comb begin
    prs_x     = {prs[DW-1], prs};
    pmag      = prs_x[DW] ? $unsigned(-prs_x) : $unsigned(prs_x);
    over      = pmag > {2'b00, cfg.pressure_limit};
    spd_x     = over ? '0 : {spd[DW-1], spd};
    smag_full = spd_x[DW] ? $unsigned(-spd_x) : $unsigned(spd_x);
    smag_c    = (smag_full > {2'b00, cfg.speed_limit}) ? cfg.speed_limit
                                                         : smag_full[LW-1:0];
    dir_c     = spd_x[DW] && (smag_c != '0);
    err       = {tgt[DW-1], tgt} - prs_x;
    errmag    = err[DW] ? $unsigned(-err) : $unsigned(err);
    go_c      = (smag_c != '0) && (errmag >= {2'b00, cfg.deadband});
  end

  logic [LW-1:0] smag;
  logic          dir_r, go_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      smag  <= smag_c;
      dir_r <= dir_c;
      go_r  <= go_c;
    end
  end

  // tick divider: timer clock over prescaler plus one, one bit per cycle
  logic [TW-1:0] tq;
  logic [SW-1:0] trem, tdiv;
  logic [SW:0]   tsh;
  logic          tbit;

  assign tdiv = {1'b0, cfg.prescaler} + 1'b1;
  assign tsh  = {trem, tq[TW-1]};
  assign tbit = tsh >= {1'b0, tdiv};

  always_ff @(posedge clk) begin
    if (cmd.tdiv_init) begin
      tq   <= cfg.timer_clock_hz;
      trem <= '0;
    end else if (cmd.tdiv_step) begin
      tq   <= {tq[TW-2:0], tbit};
      trem <= tbit ? SW'(tsh - {1'b0, tdiv}) : tsh[SW-1:0];
    end
  end

  // tick times step size in two halves through one multiplier
  logic [15:0]         mop;
  logic [TW+15:0]      mprod;
  logic [PW-1:0]       prod;

  assign mop   = cmd.mul_hi ? cfg.step_size[31:16] : cfg.step_size[15:0];
  assign mprod = {16'b0, tq} * {{TW{1'b0}}, mop};

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod <= {16'b0, mprod};
    end else if (cmd.mul_hi) begin
      prod <= prod + {mprod, 16'b0};
    end
  end

  // quotient reaches 2^QW exactly when the high product part is not below speed
  logic qbig_c;
  assign qbig_c = prod[PW-1:QW] >= {{(HW - LW){1'b0}}, smag};

  // low quotient bits, one per cycle
  logic [QW-1:0] qq;
  logic [LW-1:0] qrem;
  logic [LW:0]   qsh;
  logic          qbit, big_r;

  assign qsh  = {qrem, qq[QW-1]};
  assign qbit = qsh >= {1'b0, smag};

  always_ff @(posedge clk) begin
    if (cmd.qdiv_init) begin
      qq    <= prod[QW-1:0];
      qrem  <= prod[QW+LW-1:QW];
      big_r <= qbig_c;
    end else if (cmd.qdiv_step) begin
      qq    <= {qq[QW-2:0], qbit};
      qrem  <= qbit ? LW'(qsh - {1'b0, smag}) : qsh[LW-1:0];
    end
  end

  // reload is quotient minus one, saturated to the allowed range
  logic [QW:0] qx, qm1, rsat;

  always_comb begin
    qx  = {1'b0, qq};
    qm1 = qx - 1'b1;
    if (big_r) begin
      rsat = MAX_V;
    end else if (qx < MIN_P1) begin
      rsat = MIN_V;
    end else if (qm1 > MAX_V) begin
      rsat = MAX_V;
    end else begin
      rsat = qm1;
    end
  end

  // output register and held reload
  logic [spr_pkg::RLD_W-1:0] held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held      <= spr_pkg::RLD_W'(RELOAD_MAX);
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
      if (go_r) begin
        held <= spr_pkg::RLD_W'(rsat);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      direction <= dir_r;
      pulsing   <= go_r;
      reload    <= go_r ? spr_pkg::RLD_W'(rsat) : held;
      compare   <= go_r ? spr_pkg::CMP_W'(rsat >> 1) : '0;
    end
  end

  // status to the controller
  assign sts.go       = go_c;
  assign sts.qbig     = qbig_c;
  assign sts.out_free = !out_valid || out_ready;

endmodule

@@ rtl/step_pulse_rate_limiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_pulse_rate_limiter
// Turns a speed command plus measured and target pressure into step timer
// direction, reload and compare settings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries speed_cmd, pressure and target
//   as signed Q16.16. Each accepted beat yields exactly one output beat
//   (out_valid/out_ready) with direction, reload, compare and pulsing.
//   Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) write one
//   register each; cfg_ready is always high. Write only while idle.
//   A beat that stops pulses goes from the input check to the output load.
//   A pulsing beat runs the one-bit-per-cycle tick divider, the split
//   multiply and the quotient range check, then the low quotient bits
//   unless the quotient saturates high, and then the output load.
//   One beat is in work at a time; in_ready is high only between beats.
//   The output register lets a new beat start while a result waits; if the
//   receiver stalls, the finished beat waits until the register is free.
//   Reset restores the register defaults and sets the held reload to the
//   upper limit; no output beat is pending after reset.
// ----------------------------------------------------------------------------
module step_pulse_rate_limiter #(
  parameter int RELOAD_MIN = 1249,
  parameter int RELOAD_MAX = 4999
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [spr_pkg::DATA_W-1:0]  speed_cmd,
  input  logic signed [spr_pkg::DATA_W-1:0]  pressure,
  input  logic signed [spr_pkg::DATA_W-1:0]  target,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               direction,
  output logic [spr_pkg::RLD_W-1:0]          reload,
  output logic [spr_pkg::CMP_W-1:0]          compare,
  output logic                               pulsing,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spr_pkg::IDX_W-1:0]          cfg_index,
  input  logic [spr_pkg::DATA_W-1:0]         cfg_data
);

  // quotient bits needed to tell values above the upper limit apart
  localparam int QW = $clog2(RELOAD_MAX + 2);

  spr_pkg::cfg_t cfg;
  spr_pkg::cmd_t cmd;
  spr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // register file
  spr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  spr_ctrl #(
    .QW (QW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and output register
  spr_datapath #(
    .RELOAD_MIN (RELOAD_MIN),
    .RELOAD_MAX (RELOAD_MAX),
    .QW         (QW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg       (cfg),
    .speed_cmd (speed_cmd),
    .pressure  (pressure),
    .target    (target),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .direction (direction),
    .reload    (reload),
    .compare   (compare),
    .pulsing   (pulsing)
  );

  // one beat in work at a time
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in work");

  // compare is half the reload while pulsing
  a_cmp_half: assert property (@(posedge clk) disable iff (rst)
    out_valid && pulsing |-> compare == spr_pkg::CMP_W'(reload >> 1))
    else $error("compare does not match reload");

  // stopped pulses give a zero compare
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pulsing |-> compare == '0)
    else $error("compare nonzero with pulses stopped");

  // reload stays within its saturation range
  a_rld_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reload >= spr_pkg::RLD_W'(RELOAD_MIN)
               && reload <= spr_pkg::RLD_W'(RELOAD_MAX))
    else $error("reload out of range");

endmodule
